// ===== sv/snatap_pkg.sv =====
// ----------------------------------------------------------------------------
// SNAT address and port pool package
// Shared sizes, request and status codes, payload structs and the command
// and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package snatap_pkg;

   localparam int TABLE_SLOTS  = 16;
   localparam int BITMAP_BYTES = 128;
   localparam int BITMAP_BITS  = BITMAP_BYTES * 8;
   localparam int SLOT_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W        = $clog2(BITMAP_BITS + 1);

   typedef logic [1:0] req_code_type;
   localparam req_code_type REQ_ADD  = 2'd0;
   localparam req_code_type REQ_DEL  = 2'd1;
   localparam req_code_type REQ_GET  = 2'd2;
   localparam req_code_type REQ_NONE = 2'd3;

   typedef logic [2:0] status_code_type;
   localparam status_code_type ST_OK      = 3'd0;
   localparam status_code_type ST_EXISTS  = 3'd1;
   localparam status_code_type ST_MISSING = 3'd2;
   localparam status_code_type ST_NO_PORT = 3'd3;
   localparam status_code_type ST_FULL    = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] dst_ip;
      logic [15:0] dest_port;
      logic [31:0] snat_ip;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] mapped_ip;
      logic [15:0] src_port;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic apply;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
   } dp_stat_type;

endpackage

// ===== sv/snatap_ctrl.sv =====
// ----------------------------------------------------------------------------
// SNAT pool controller
// Sequences one request: take it, scan the slot table, apply the update.
// ----------------------------------------------------------------------------
module snatap_ctrl
   import snatap_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_code_type req_type,
   input  dp_stat_type  stat,
   output dp_cmd_type   cmd,
   output logic         busy
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   assign take = start && (state_ff == S_IDLE) && (req_type != REQ_NONE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_last) state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.load  = take;
   assign cmd.scan  = (state_ff == S_SCAN);
   assign cmd.apply = (state_ff == S_APPLY);
   assign busy      = (state_ff != S_IDLE);

   a_take_scans: assert property (@(posedge clock) disable iff (reset)
      take |=> state_ff == S_SCAN) else $error("accepted request did not start a scan");

   a_apply_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APPLY |=> state_ff == S_IDLE) else $error("apply lasted more than a cycle");

   a_ignore_none: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !(start && req_type != REQ_NONE)) |=> state_ff == S_IDLE)
      else $error("left idle without a request");

endmodule

// ===== sv/snatap_dp.sv =====
// ----------------------------------------------------------------------------
// SNAT pool datapath
// Slot table, per-slot port fill counts, port base register, the scan
// over the table and the registered result.
// ----------------------------------------------------------------------------
module snatap_dp
   import snatap_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   input  req_item_type req_payload,
   input  logic         csr_valid,
   input  logic [15:0]  csr_wdata,
   output logic         rsp_valid,
   output rsp_item_type rsp_payload
);

   // Ports are always claimed lowest first and a slot's bitmap is only ever
   // cleared as a whole, so the taken bits form a prefix: a count holds it.
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [31:0]            key_ip_ff   [TABLE_SLOTS];
   logic [15:0]            key_port_ff [TABLE_SLOTS];
   logic [31:0]            src_ip_ff   [TABLE_SLOTS];
   logic [CNT_W-1:0]       cnt_ff      [TABLE_SLOTS];

   logic [15:0]  port_base_ff;
   req_item_type req_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic              hit_ff, free_ff;
   logic [SLOT_W-1:0] hit_slot_ff, free_slot_ff;
   logic              rsp_valid_ff;
   rsp_item_type      rsp_ff, rsp_in;

   logic        key_match;
   logic [31:0] cnt_ext;
   logic        port_left;

   assign key_match = valid_ff[idx_ff] && (key_ip_ff[idx_ff] == req_ff.dst_ip)
                      && (key_port_ff[idx_ff] == req_ff.dest_port);
   assign stat.scan_last = (idx_ff == SLOT_W'(TABLE_SLOTS - 1));

   assign cnt_ext   = 32'(cnt_ff[hit_slot_ff]);
   assign port_left = (cnt_ff[hit_slot_ff] != CNT_W'(BITMAP_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         port_base_ff <= 16'd1024;
      end else if (csr_valid) begin
         port_base_ff <= csr_wdata;
      end
   end

   // Scan: one slot per cycle, remembering the first match and first hole.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_payload;
         idx_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + SLOT_W'(1);
         if (!hit_ff && key_match) begin
            hit_ff      <= 1'b1;
            hit_slot_ff <= idx_ff;
         end
         if (!free_ff && !valid_ff[idx_ff]) begin
            free_ff      <= 1'b1;
            free_slot_ff <= idx_ff;
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.status = ST_OK;
      case (req_ff.req_type)
         REQ_ADD: begin
            if (hit_ff) rsp_in.status = ST_EXISTS;
            else if (!free_ff) rsp_in.status = ST_FULL;
         end
         REQ_DEL: begin
            if (!hit_ff) rsp_in.status = ST_MISSING;
         end
         default: begin
            if (!hit_ff) begin
               rsp_in.status = ST_MISSING;
            end else begin
               rsp_in.mapped_ip = src_ip_ff[hit_slot_ff];
               if (port_left) rsp_in.src_port = port_base_ff + cnt_ext[15:0];
               else rsp_in.status = ST_NO_PORT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.apply) begin
         case (req_ff.req_type)
            REQ_ADD: begin
               if (!hit_ff && free_ff) valid_ff[free_slot_ff] <= 1'b1;
            end
            REQ_DEL: begin
               if (hit_ff) valid_ff[hit_slot_ff] <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         if (req_ff.req_type == REQ_ADD && !hit_ff && free_ff) begin
            key_ip_ff[free_slot_ff]   <= req_ff.dst_ip;
            key_port_ff[free_slot_ff] <= req_ff.dest_port;
            src_ip_ff[free_slot_ff]   <= req_ff.snat_ip;
            cnt_ff[free_slot_ff]      <= '0;
         end else if (req_ff.req_type == REQ_GET && hit_ff && port_left) begin
            cnt_ff[hit_slot_ff] <= cnt_ff[hit_slot_ff] + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.apply;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.apply)) else $error("result without an apply cycle");

   a_port_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ST_OK) |-> rsp_ff.src_port == 16'd0)
      else $error("port reported on a failed request");

   a_scan_wraps: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && stat.scan_last) |=> !cmd.scan) else $error("scan ran past the table");

endmodule

// ===== sv/snat_address_port_pool_unit.sv =====
// ----------------------------------------------------------------------------
// SNAT address and port pool unit
// Source-NAT table keyed by destination address and port, with per-entry
// source port allocation from a configurable base.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Add, delete and get
// each run the scan and apply steps in turn before the next request can be
// taken: the controller walks the slot table one entry per cycle to find the
// key and the lowest free slot, then applies the update in the apply step that
// follows the last entry. The result is driven on rsp_payload for exactly one
// cycle with rsp_valid high, in the cycle after the apply step, and that cycle
// overlaps the first cycle in which a new request can be taken. The receiver
// cannot hold the result off, so it must take every transfer.
// Request code 3 is accepted and dropped: no result and no state change.
// Source ports are handed out lowest first from port_base and wrap modulo
// 65536; each entry owns BITMAP_BYTES * 8 ports, kept as a fill count since
// ports are only returned when the entry is deleted. There is no clearing pass
// after reset. The port_base register is written through the csr channel,
// which is always ready, and must only be written while the unit is idle.
// ----------------------------------------------------------------------------
module snat_address_port_pool_unit
   import snatap_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   output rsp_item_type rsp_payload,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Configuration writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;

   snatap_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_payload.req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   snatap_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
